### hw/rtl/elevator_direction_controller_macros.svh
// assertion macros used by the edc_ctrl module of the elevator direction controller
// no dependencies; included by edc_ctrl, which carries concurrent checks
`ifndef ELEVATOR_DIRECTION_CONTROLLER_MACROS_SVH
`define ELEVATOR_DIRECTION_CONTROLLER_MACROS_SVH

// same-cycle implication, quiet during reset
`define EDC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define EDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/edc_pkg.sv
// shared types, codes and defaults of the elevator direction controller
// no dependencies; used by edc_ctrl and the top level
package edc_pkg;

   localparam int FLOOR_W   = 3;
   localparam int CNT_OUT_W = 3;
   localparam int IRS_W     = 16;

   localparam int FLOORS_DEF      = 5;
   localparam int CAPACITY_DEF    = 5;
   localparam int QUEUE_DEPTH_DEF = 8;

   localparam logic [IRS_W-1:0] IRS_RESET = 16'd250;
   localparam logic [IRS_W-1:0] IDLE_MAX  = 16'hFFFF;

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_STEP    = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_FLOORS = 2'd1,
      ERR_FULL   = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      DIR_UP   = 2'd0,
      DIR_DOWN = 2'd1,
      DIR_IDLE = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SERVE,
      ST_BOARD,
      ST_BWAIT,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 accepted;
      err_type              error_code;
      logic [FLOOR_W-1:0]   car_floor;
      dir_type              direction;
      logic                 moved;
      logic                 door_cycled;
      logic [CNT_OUT_W-1:0] alighted;
      logic [CNT_OUT_W-1:0] boarded;
      logic [CNT_OUT_W-1:0] occupancy;
   } rsp_type;

endpackage

### hw/rtl/edc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module edc_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 40,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/edc_ctrl.sv
// sequencer and car state of the elevator direction controller
// depends on edc_pkg, edc_ram and the assertion macro header
`include "elevator_direction_controller_macros.svh"

module edc_ctrl #(
   parameter int FLOORS      = edc_pkg::FLOORS_DEF,
   parameter int CAPACITY    = edc_pkg::CAPACITY_DEF,
   parameter int QUEUE_DEPTH = edc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [edc_pkg::FLOOR_W-1:0] req_from_floor,
   input  logic [edc_pkg::FLOOR_W-1:0] req_to_floor,
   input  logic [edc_pkg::IRS_W-1:0]   idle_return_steps,
   output logic                        res_valid,
   output edc_pkg::rsp_type            res,
   input  logic                        res_load
);

   localparam int FIDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = FILL_W + 1;
   localparam int DEPTH  = FLOORS * QUEUE_DEPTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW     = edc_pkg::FLOOR_W;
   localparam int OW     = edc_pkg::CNT_OUT_W;

   edc_pkg::state_type   state_ff, state_in;
   logic [FW-1:0]        car_ff, car_in;
   edc_pkg::dir_type     dir_ff, dir_in;
   logic [CNT_W-1:0]     rc_ff, rc_in;
   logic [FLOORS-1:0]    up_ff, up_in, dn_ff, dn_in, cc_ff, cc_in;
   logic [CNT_W-1:0]     rpt_ff [FLOORS];
   logic [CNT_W-1:0]     rpt_in [FLOORS];
   logic [HEAD_W-1:0]    head_ff [FLOORS];
   logic [HEAD_W-1:0]    head_in [FLOORS];
   logic [FILL_W-1:0]    fill_ff [FLOORS];
   logic [FILL_W-1:0]    fill_in [FLOORS];
   logic [edc_pkg::IRS_W-1:0] idle_ff, idle_in;
   edc_pkg::rsp_type     res_ff, res_in;

   logic                 wr_en, rd_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [FW-1:0]        wr_data, rd_data;

   logic [FIDX_W-1:0]    fi;
   logic [FLOORS-1:0]    wants;
   logic                 door_ok, board_go;

   // target fifo storage for all floors
   edc_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_wait_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // per-floor demand and serve conditions at the car's floor
   always_comb begin
      fi = FIDX_W'(car_ff - FW'(1));
      for (int g = 0; g < FLOORS; g++) begin
         wants[g] = cc_ff[g] | up_ff[g] | dn_ff[g] | (rpt_ff[g] != '0) | (fill_ff[g] != '0);
      end
      door_ok  = wants[fi] && !((rc_ff >= CNT_W'(CAPACITY)) && (rpt_ff[fi] == '0));
      board_go = (fill_ff[fi] != '0) && (rc_ff < CNT_W'(CAPACITY));
      rd_addr  = ADDR_W'(int'(fi) * QUEUE_DEPTH + int'(head_ff[fi]));
   end

   // datapath: arrival, unload, boarding, direction choice, move and idle return call
   always_comb begin
      logic              a_ok, a_full, t_ok, upf, dnf, at_top, at_bot, mv_up, mv_dn;
      logic [FIDX_W-1:0] afi, ti, nfi;
      logic [SUM_W-1:0]  slot;
      logic [FLOORS-1:0] above, below;
      edc_pkg::dir_type  dir_nx;

      car_in  = car_ff;
      dir_in  = dir_ff;
      rc_in   = rc_ff;
      up_in   = up_ff;
      dn_in   = dn_ff;
      cc_in   = cc_ff;
      rpt_in  = rpt_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      idle_in = idle_ff;
      res_in  = res_ff;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      wr_data = req_to_floor;

      a_ok   = (req_from_floor != '0) && (int'(req_from_floor) <= FLOORS)
               && (req_to_floor != '0) && (int'(req_to_floor) <= FLOORS)
               && (req_from_floor != req_to_floor);
      afi    = FIDX_W'(req_from_floor - FW'(1));
      a_full = fill_ff[afi] >= FILL_W'(QUEUE_DEPTH);
      slot   = SUM_W'(head_ff[afi]) + SUM_W'(fill_ff[afi]);
      if (slot >= SUM_W'(QUEUE_DEPTH)) begin
         slot = slot - SUM_W'(QUEUE_DEPTH);
      end
      wr_addr = ADDR_W'(int'(afi) * QUEUE_DEPTH + int'(slot));

      t_ok = (rd_data != '0) && (int'(rd_data) <= FLOORS);
      ti   = FIDX_W'(rd_data - FW'(1));

      for (int g = 0; g < FLOORS; g++) begin
         above[g] = g > int'(fi);
         below[g] = g < int'(fi);
      end
      upf    = up_ff[fi] | (|(wants & above));
      dnf    = dn_ff[fi] | (|(wants & below));
      at_top = fi == FIDX_W'(FLOORS - 1);
      at_bot = fi == '0;
      mv_up  = 1'b0;
      mv_dn  = 1'b0;
      dir_nx = dir_ff;
      nfi    = fi;

      unique case (state_ff)
         edc_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_in.car_floor   = car_ff;
               res_in.direction   = dir_ff;
               res_in.occupancy   = OW'(rc_ff);
               res_in.moved       = 1'b0;
               res_in.door_cycled = 1'b0;
               res_in.alighted    = '0;
               res_in.boarded     = '0;
               res_in.accepted    = 1'b1;
               res_in.error_code  = edc_pkg::ERR_NONE;
               if (req_kind == edc_pkg::KIND_ARRIVAL) begin
                  if (!a_ok) begin
                     res_in.accepted   = 1'b0;
                     res_in.error_code = edc_pkg::ERR_FLOORS;
                  end else if (a_full) begin
                     res_in.accepted   = 1'b0;
                     res_in.error_code = edc_pkg::ERR_FULL;
                  end else begin
                     wr_en        = 1'b1;
                     fill_in[afi] = fill_ff[afi] + FILL_W'(1);
                     if (req_from_floor > req_to_floor) begin
                        dn_in[afi] = 1'b1;
                     end else begin
                        up_in[afi] = 1'b1;
                     end
                  end
               end
            end
         end
         edc_pkg::ST_SERVE: begin
            // door cycle and unload
            if (door_ok) begin
               res_in.door_cycled = 1'b1;
               res_in.alighted    = OW'(rpt_ff[fi]);
               rc_in              = (rpt_ff[fi] > rc_ff) ? '0 : rc_ff - rpt_ff[fi];
               rpt_in[fi]         = '0;
            end
         end
         edc_pkg::ST_BOARD: begin
            rd_en = board_go;
         end
         edc_pkg::ST_BWAIT: begin
            // one waiting passenger boards
            head_in[fi] = (head_ff[fi] == HEAD_W'(QUEUE_DEPTH - 1)) ? '0
                          : head_ff[fi] + HEAD_W'(1);
            fill_in[fi] = fill_ff[fi] - FILL_W'(1);
            if (t_ok) begin
               rpt_in[ti] = rpt_ff[ti] + CNT_W'(1);
               cc_in[ti]  = 1'b1;
            end
            rc_in          = rc_ff + CNT_W'(1);
            res_in.boarded = res_ff.boarded + OW'(1);
         end
         edc_pkg::ST_DECIDE: begin
            unique case (dir_ff)
               edc_pkg::DIR_UP: begin
                  if (at_top || (!upf && dnf)) begin
                     if (!(at_top && !dnf)) begin
                        dir_nx = edc_pkg::DIR_DOWN;
                        mv_dn  = !at_bot;
                     end
                  end else if (!upf && !dnf) begin
                     dir_nx = edc_pkg::DIR_IDLE;
                  end else begin
                     mv_up = !at_top;
                  end
               end
               edc_pkg::DIR_DOWN: begin
                  if (at_bot || (!dnf && upf)) begin
                     if (dnf || upf) begin
                        dir_nx = edc_pkg::DIR_UP;
                        mv_up  = !at_top;
                     end
                  end else if (!upf && !dnf) begin
                     dir_nx = edc_pkg::DIR_IDLE;
                  end else begin
                     mv_dn = !at_bot;
                  end
               end
               edc_pkg::DIR_IDLE: begin
                  if (upf) begin
                     dir_nx = edc_pkg::DIR_UP;
                     mv_up  = !at_top;
                  end else if (dnf) begin
                     dir_nx = edc_pkg::DIR_DOWN;
                     mv_dn  = !at_bot;
                  end else begin
                     dir_nx = edc_pkg::DIR_IDLE;
                  end
               end
            endcase

            // move one floor
            if (mv_up) begin
               nfi        = fi + FIDX_W'(1);
               cc_in[fi]  = 1'b0;
               up_in[fi]  = 1'b0;
               cc_in[nfi] = 1'b0;
               car_in     = car_ff + FW'(1);
            end else if (mv_dn) begin
               nfi        = fi - FIDX_W'(1);
               cc_in[fi]  = 1'b0;
               dn_in[fi]  = 1'b0;
               cc_in[nfi] = 1'b0;
               car_in     = car_ff - FW'(1);
            end

            // idle count and return call
            if (mv_up || mv_dn) begin
               idle_in = '0;
            end else begin
               if (idle_ff != edc_pkg::IDLE_MAX) begin
                  idle_in = idle_ff + 16'd1;
               end
               cc_in[fi] = 1'b0;
               if ((idle_in >= idle_return_steps) && !at_bot) begin
                  cc_in[0] = 1'b1;
               end
            end

            // hall calls at the new floor
            if ((rpt_ff[nfi] == '0) || (fill_ff[nfi] == '0)) begin
               up_in[nfi] = 1'b0;
               dn_in[nfi] = 1'b0;
            end

            dir_in           = dir_nx;
            res_in.moved     = mv_up | mv_dn;
            res_in.car_floor = car_in;
            res_in.direction = dir_nx;
            res_in.occupancy = OW'(rc_ff);
         end
         edc_pkg::ST_DONE: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         edc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == edc_pkg::KIND_ARRIVAL) ? edc_pkg::ST_DONE
                          : edc_pkg::ST_SERVE;
            end
         end
         edc_pkg::ST_SERVE:  state_in = door_ok ? edc_pkg::ST_BOARD : edc_pkg::ST_DECIDE;
         edc_pkg::ST_BOARD:  state_in = board_go ? edc_pkg::ST_BWAIT : edc_pkg::ST_DECIDE;
         edc_pkg::ST_BWAIT:  state_in = edc_pkg::ST_BOARD;
         edc_pkg::ST_DECIDE: state_in = edc_pkg::ST_DONE;
         edc_pkg::ST_DONE: begin
            if (res_load) begin
               state_in = edc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = state_ff != edc_pkg::ST_IDLE;
      res_valid = state_ff == edc_pkg::ST_DONE;
      res       = res_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edc_pkg::ST_IDLE;
         car_ff   <= FW'(1);
         dir_ff   <= edc_pkg::DIR_IDLE;
         rc_ff    <= '0;
         up_ff    <= '0;
         dn_ff    <= '0;
         cc_ff    <= '0;
         idle_ff  <= '0;
         for (int g = 0; g < FLOORS; g++) begin
            rpt_ff[g]  <= '0;
            head_ff[g] <= '0;
            fill_ff[g] <= '0;
         end
      end else begin
         state_ff <= state_in;
         car_ff   <= car_in;
         dir_ff   <= dir_in;
         rc_ff    <= rc_in;
         up_ff    <= up_in;
         dn_ff    <= dn_in;
         cc_ff    <= cc_in;
         idle_ff  <= idle_in;
         rpt_ff   <= rpt_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   `EDC_ASSERT_IMP(a_occ_cap, 1'b1, rc_ff <= CNT_W'(CAPACITY), "occupancy above capacity")
   `EDC_ASSERT_IMP(a_floor_range, 1'b1, (car_ff != '0) && (int'(car_ff) <= FLOORS), "bad floor")
   `EDC_ASSERT_NEXT(a_read_wait, rd_en, state_ff == edc_pkg::ST_BWAIT, "read without wait")

endmodule

### hw/rtl/elevator_direction_controller.sv
// Single-car elevator controller. An arrival beat goes from idle straight to its
// result; a control-step beat runs serve, then board and board-wait for each
// boarding passenger (at most CAPACITY) when the door cycles, then decide,
// paced by the sequencer reading one queued target per access from the single
// read port of the waiting-target ram. Results sit in an output register, so
// the next beat is taken while a finished result waits. idle_return_steps is
// written by the user on the csr port while no beat is in flight (not enforced).
// depends on edc_pkg and edc_ctrl
module elevator_direction_controller #(
   parameter int FLOORS      = edc_pkg::FLOORS_DEF,
   parameter int CAPACITY    = edc_pkg::CAPACITY_DEF,
   parameter int QUEUE_DEPTH = edc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [edc_pkg::FLOOR_W-1:0]   req_from_floor,
   input  logic [edc_pkg::FLOOR_W-1:0]   req_to_floor,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic [1:0]                    rsp_error_code,
   output logic [edc_pkg::FLOOR_W-1:0]   rsp_car_floor,
   output logic [1:0]                    rsp_direction,
   output logic                          rsp_moved,
   output logic                          rsp_door_cycled,
   output logic [edc_pkg::CNT_OUT_W-1:0] rsp_alighted,
   output logic [edc_pkg::CNT_OUT_W-1:0] rsp_boarded,
   output logic [edc_pkg::CNT_OUT_W-1:0] rsp_occupancy,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [edc_pkg::IRS_W-1:0]     csr_idle_return_steps
);

   logic [edc_pkg::IRS_W-1:0] irs_ff;
   logic                      rsp_valid_ff;
   edc_pkg::rsp_type          rsp_ff;
   logic                      res_valid, res_load;
   edc_pkg::rsp_type          res;

   edc_ctrl #(
      .FLOORS      (FLOORS),
      .CAPACITY    (CAPACITY),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_from_floor    (req_from_floor),
      .req_to_floor      (req_to_floor),
      .idle_return_steps (irs_ff),
      .res_valid         (res_valid),
      .res               (res),
      .res_load          (res_load)
   );

   // config register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         irs_ff <= edc_pkg::IRS_RESET;
      end else if (csr_valid && csr_ready) begin
         irs_ff <= csr_idle_return_steps;
      end
   end

   // output register
   assign res_load = res_valid && (!rsp_valid_ff || !rsp_stall);
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   // result beat fields
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_ff.accepted;
   assign rsp_error_code  = rsp_ff.error_code;
   assign rsp_car_floor   = rsp_ff.car_floor;
   assign rsp_direction   = rsp_ff.direction;
   assign rsp_moved       = rsp_ff.moved;
   assign rsp_door_cycled = rsp_ff.door_cycled;
   assign rsp_alighted    = rsp_ff.alighted;
   assign rsp_boarded     = rsp_ff.boarded;
   assign rsp_occupancy   = rsp_ff.occupancy;

endmodule

### verif/elevator_direction_controller_tb.sv
// self-checking bench for the elevator direction controller: random and directed
// arrival and control-step beats checked against an in-bench car model
// depends on edc_pkg and elevator_direction_controller
module elevator_direction_controller_tb;

   localparam int NFL   = 5;
   localparam int CAP   = 5;
   localparam int QDEP  = 8;
   localparam int WDOG  = 4000;
   localparam int LONG_HOLD = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = 1'b0;
   logic [2:0] req_from_floor = 3'd0;
   logic [2:0] req_to_floor = 3'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_accepted;
   logic [1:0] rsp_error_code;
   logic [2:0] rsp_car_floor;
   logic [1:0] rsp_direction;
   logic rsp_moved, rsp_door_cycled;
   logic [2:0] rsp_alighted, rsp_boarded, rsp_occupancy;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_idle_return_steps = 16'd0;

   elevator_direction_controller DUT (.*);

   always #10 clock = ~clock;

   // car model state
   logic [15:0] m_irs;
   int m_floor, m_riders, m_idle;
   edc_pkg::dir_type m_dir;
   bit m_up[1:NFL], m_dn[1:NFL], m_car[1:NFL];
   int m_bound[1:NFL], m_head[1:NFL], m_fill[1:NFL];
   int m_queue[1:NFL][QDEP];

   edc_pkg::rsp_type expected_q[$];
   int errors = 0, results = 0, steps = 0, arrivals = 0;
   int quiet = 0;
   bit idle_rsp = 1'b1, idle_req = 1'b1;
   int hold_rsp = 0;
   int hold_req = 0;
   int hold_ack = 0;

   function automatic bit floor_busy(int g);
      return m_car[g] || m_up[g] || m_dn[g] || m_bound[g] != 0 || m_fill[g] != 0;
   endfunction

   function automatic bit car_up();
      int f = m_floor;
      if (f >= NFL) return 0;
      m_car[f] = 0; m_floor = f + 1; m_up[f] = 0; m_car[f + 1] = 0;
      return 1;
   endfunction

   function automatic bit car_down();
      int f = m_floor;
      if (f <= 1) return 0;
      m_car[f] = 0; m_floor = f - 1; m_dn[f] = 0; m_car[f - 1] = 0;
      return 1;
   endfunction

   function automatic bit pick_move();
      int f = m_floor;
      bit upf = m_up[f];
      bit dnf = m_dn[f];
      if (!upf) for (int g = f + 1; g <= NFL; g++) if (floor_busy(g)) begin upf = 1; break; end
      if (!dnf) for (int g = f - 1; g >= 1; g--) if (floor_busy(g)) begin dnf = 1; break; end
      if (m_dir == edc_pkg::DIR_UP) begin
         if (f == NFL || (!upf && dnf)) begin
            if (f == NFL && !dnf) return 0;
            m_dir = edc_pkg::DIR_DOWN;
            return car_down();
         end
         if (!upf && !dnf) begin m_dir = edc_pkg::DIR_IDLE; return 0; end
         return car_up();
      end
      if (m_dir == edc_pkg::DIR_DOWN) begin
         if (f == 1 || (!dnf && upf)) begin
            if (!dnf && !upf) return 0;
            m_dir = edc_pkg::DIR_UP;
            return car_up();
         end
         if (!upf && !dnf) begin m_dir = edc_pkg::DIR_IDLE; return 0; end
         return car_down();
      end
      if (!upf && !dnf) return 0;
      if (upf) begin m_dir = edc_pkg::DIR_UP; return car_up(); end
      m_dir = edc_pkg::DIR_DOWN;
      return car_down();
   endfunction

   function automatic void model_reset();
      m_irs = edc_pkg::IRS_RESET; m_floor = 1; m_dir = edc_pkg::DIR_IDLE;
      m_riders = 0; m_idle = 0;
      for (int g = 1; g <= NFL; g++) begin
         m_up[g] = 0; m_dn[g] = 0; m_car[g] = 0; m_bound[g] = 0; m_head[g] = 0; m_fill[g] = 0;
      end
   endfunction

   // work out the result of one beat and advance the model
   function automatic edc_pkg::rsp_type predict_car(bit kind, int from, int to);
      edc_pkg::rsp_type r;
      int f, t;
      r = '0;
      r.accepted = 1'b1;
      r.error_code = edc_pkg::ERR_NONE;
      if (kind == edc_pkg::KIND_ARRIVAL) begin
         if (from < 1 || from > NFL || to < 1 || to > NFL || from == to) begin
            r.accepted = 0; r.error_code = edc_pkg::ERR_FLOORS;
         end else if (m_fill[from] >= QDEP) begin
            r.accepted = 0; r.error_code = edc_pkg::ERR_FULL;
         end else begin
            m_queue[from][(m_head[from] + m_fill[from]) % QDEP] = to;
            m_fill[from]++;
            if (from > to) m_dn[from] = 1; else m_up[from] = 1;
         end
      end else begin
         f = m_floor;
         if (floor_busy(f) && !(m_riders >= CAP && m_bound[f] == 0)) begin
            r.door_cycled = 1;
            r.alighted = 3'(m_bound[f]);
            m_riders = (m_bound[f] > m_riders) ? 0 : m_riders - m_bound[f];
            m_bound[f] = 0;
            while (m_fill[f] != 0 && m_riders < CAP) begin
               t = m_queue[f][m_head[f]];
               m_head[f] = (m_head[f] + 1) % QDEP;
               m_fill[f]--;
               m_bound[t]++; m_car[t] = 1;
               m_riders++;
               r.boarded++;
            end
         end
         r.moved = pick_move();
         if (r.moved) m_idle = 0;
         else begin
            if (m_idle < 65535) m_idle++;
            m_car[m_floor] = 0;
            if (m_idle >= m_irs && m_floor != 1) m_car[1] = 1;
         end
         f = m_floor;
         if (m_bound[f] == 0 || m_fill[f] == 0) begin m_up[f] = 0; m_dn[f] = 0; end
      end
      r.car_floor = 3'(m_floor);
      r.direction = m_dir;
      r.occupancy = 3'(m_riders);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch on result %0d: %s got %0d expected %0d", results, what, got, want);
   endtask

   // send one beat, predicting at acceptance; valid stays up into the next beat
   task automatic send_beat(bit kind, int from, int to);
      while (idle_req && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_from_floor <= from[2:0];
      req_to_floor <= to[2:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(predict_car(kind, from, to));
      if (kind == edc_pkg::KIND_STEP) steps++; else arrivals++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_return_steps(logic [15:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_idle_return_steps <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      m_irs = v;
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      edc_pkg::rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         quiet = 0;
         results++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            w = expected_q.pop_front();
            if (rsp_accepted !== w.accepted) report_mismatch("accepted", rsp_accepted, w.accepted);
            if (rsp_error_code !== w.error_code)
               report_mismatch("error_code", rsp_error_code, w.error_code);
            if (rsp_car_floor !== w.car_floor)
               report_mismatch("car_floor", rsp_car_floor, w.car_floor);
            if (rsp_direction !== w.direction)
               report_mismatch("direction", rsp_direction, w.direction);
            if (rsp_moved !== w.moved) report_mismatch("moved", rsp_moved, w.moved);
            if (rsp_door_cycled !== w.door_cycled)
               report_mismatch("door_cycled", rsp_door_cycled, w.door_cycled);
            if (rsp_alighted !== w.alighted)
               report_mismatch("alighted", rsp_alighted, w.alighted);
            if (rsp_boarded !== w.boarded) report_mismatch("boarded", rsp_boarded, w.boarded);
            if (rsp_occupancy !== w.occupancy)
               report_mismatch("occupancy", rsp_occupancy, w.occupancy);
         end
      end else if (!reset && !(req_valid && !req_stall)) begin
         quiet++;
      end
   end

   // receiver stall: a long hold when requested, or random bursts
   always @(posedge clock) begin
      if (hold_ack != hold_req) begin
         rsp_stall <= 1'b1;
         hold_ack <= hold_req;
         hold_rsp <= LONG_HOLD;
      end else if (hold_rsp > 0) begin
         rsp_stall <= 1'b1;
         hold_rsp <= hold_rsp - 1;
      end else if (idle_rsp && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         hold_rsp <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (quiet >= WDOG) begin
         $display("watchdog expired with %0d results pending", expected_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      int fl;
      send_beat(edc_pkg::KIND_STEP, 0, 0);             // idle car at floor 1
      send_beat(edc_pkg::KIND_ARRIVAL, 0, 3);          // floor zero
      send_beat(edc_pkg::KIND_ARRIVAL, 7, 2);          // floor above top
      send_beat(edc_pkg::KIND_ARRIVAL, 3, 3);          // same floor
      send_beat(edc_pkg::KIND_ARRIVAL, 2, 0);
      send_beat(edc_pkg::KIND_ARRIVAL, 6, 7);
      // fill floor 1 past its queue depth
      for (int i = 0; i < QDEP + 1; i++) send_beat(edc_pkg::KIND_ARRIVAL, 1, 5);
      send_beat(edc_pkg::KIND_ARRIVAL, 5, 1);
      for (int i = 0; i < 8; i++) send_beat(edc_pkg::KIND_STEP, 0, 0);
      fl = 4;
      send_beat(edc_pkg::KIND_ARRIVAL, fl, 2);
   endtask

   task automatic test_full_car();
      // full car passing a floor with waiting riders and nobody alighting
      for (int i = 0; i < 6; i++) send_beat(edc_pkg::KIND_ARRIVAL, 2, 5);
      send_beat(edc_pkg::KIND_ARRIVAL, 3, 1);
      for (int i = 0; i < 30; i++) send_beat(edc_pkg::KIND_STEP, 0, 0);
   endtask

   task automatic test_idle_return(logic [15:0] v, int n);
      write_return_steps(v);
      send_beat(edc_pkg::KIND_ARRIVAL, 1, 4);
      for (int i = 0; i < n; i++) send_beat(edc_pkg::KIND_STEP, 0, 0);
   endtask

   task automatic test_random(int n);
      int a, b;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            a = $urandom_range(0, 7); b = $urandom_range(0, 7);
            send_beat(edc_pkg::KIND_ARRIVAL, a, b);
         end else if ($urandom_range(0, 2) == 0) begin
            a = $urandom_range(1, NFL);
            b = $urandom_range(1, NFL - 1);
            if (b >= a) b++;
            send_beat(edc_pkg::KIND_ARRIVAL, a, b);
         end else begin
            send_beat(edc_pkg::KIND_STEP, 0, 0);
         end
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_req++;
      test_random(40);
      // sender pause until everything has drained
      wait_drained();
      test_random(20);
   endtask

   initial begin
      model_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_car();
      test_idle_return(16'd1, 20);
      test_idle_return(16'd65535, 20);
      test_idle_return(16'd3, 30);
      test_backpressure();
      write_return_steps(16'd40);
      test_random(900);
      write_return_steps(16'd7);
      test_random(250);
      // last part with no idling on either side
      idle_req = 0;
      idle_rsp = 0;
      test_random(100);
      wait_drained();
      $display("covered %0d arrivals and %0d control steps, %0d results checked",
               arrivals, steps, results);
      $display("return-call delay swept over 1, 3, 7, 40, 250 and 65535 steps");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
